>>> rtl/convex_polygon_clipper_assert.svh
// Assertion macros for the clipper top level, which checks its own logic.
// Each macro is used inside a module that has clk and rst_n in scope.
`ifndef CONVEX_POLYGON_CLIPPER_ASSERT_SVH
`define CONVEX_POLYGON_CLIPPER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("convex_polygon_clipper assertion failed");

// Next-cycle implication, checked outside reset.
`define CCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("convex_polygon_clipper assertion failed");

`endif

>>> rtl/ccp_pkg.sv
package ccp_pkg;

  localparam int MAX_CLIP_VERTICES = 8;
  localparam int MAX_LIST_VERTICES = 24;
  localparam int COORD_BITS        = 16;

  localparam int CMD_W = 2;
  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_CLEAR_CLIP  = 2'd0;
  localparam cmd_t CMD_ADD_CLIP    = 2'd1;
  localparam cmd_t CMD_ADD_SUBJECT = 2'd2;
  localparam cmd_t CMD_RUN         = 2'd3;

endpackage

>>> rtl/convex_polygon_clipper.sv
// Convex polygon clipper for Q12.4 vertices.
// Input requests carry a command and one vertex: clear the clip polygon,
// append a clip vertex, append a subject vertex, or run. Loads need no
// result. A run clips the subject against each clip edge in turn and
// then sends the clipped polygon out, one vertex per result request, the
// final one flagged last_vertex; an empty polygon gives a single result
// with empty_result set and zero coordinates.
// Steps of a run: each clip edge first reads its clip vertices and the
// last list vertex, then each list vertex is read and tested against the
// edge, a kept vertex is pushed to the other list, and a crossing starts
// the two-step multiply and the bit-per-cycle divider that produce the
// intersection point. Output loads each vertex from the registered list read.
// A two-entry request queue lets loads queue up behind a busy run.
// Reset clears the counts and the overflow flag; clip and list memories are
// not cleared and are only read below their counts.
// When the receiver stalls, the result register holds and the sequencer
// waits; the queue then fills and raises in_stall.
module convex_polygon_clipper #(
  parameter int MAX_CLIP_VERTICES = ccp_pkg::MAX_CLIP_VERTICES,
  parameter int MAX_LIST_VERTICES = ccp_pkg::MAX_LIST_VERTICES,
  parameter int COORD_BITS        = ccp_pkg::COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ccp_pkg::cmd_t                in_command,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic                         out_last_vertex,
  output logic                         out_empty_result,
  output logic                         out_overflowed
);

  `include "convex_polygon_clipper_assert.svh"

  logic                         q_valid;
  ccp_pkg::cmd_t                q_cmd;
  logic signed [COORD_BITS-1:0] q_x;
  logic signed [COORD_BITS-1:0] q_y;
  logic                         q_pop;

  // Front end: accepts requests into a short queue.
  ccp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_x        (q_x),
    .q_y        (q_y),
    .q_pop      (q_pop)
  );

  // Back end: executes loads and runs the clipping passes.
  ccp_back #(
    .MAX_CLIP_VERTICES (MAX_CLIP_VERTICES),
    .MAX_LIST_VERTICES (MAX_LIST_VERTICES),
    .COORD_BITS        (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_x     (q_x),
    .q_y     (q_y),
    .q_pop   (q_pop),
    .o_valid (out_valid),
    .o_stall (out_stall),
    .o_x     (out_x),
    .o_y     (out_y),
    .o_last  (out_last_vertex),
    .o_empty (out_empty_result),
    .o_ovf   (out_overflowed)
  );

  // An empty result is always the only, and thus last, result of a run.
  `CCP_ASSERT_NOW(a_empty_is_last, out_valid && out_empty_result, out_last_vertex)
  // An empty result carries zero coordinates.
  `CCP_ASSERT_NOW(a_empty_zero, out_valid && out_empty_result, (out_x == '0) && (out_y == '0))
  // The sequencer only takes a request from the queue when one is present.
  `CCP_ASSERT_NOW(a_pop_has_data, q_pop, q_valid)

endmodule

>>> rtl/ccp_ram.sv
module ccp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ccp_front.sv
module ccp_front #(
  parameter int COORD_BITS = ccp_pkg::COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ccp_pkg::cmd_t                in_command,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  output logic                         q_valid,
  output ccp_pkg::cmd_t                q_cmd,
  output logic signed [COORD_BITS-1:0] q_x,
  output logic signed [COORD_BITS-1:0] q_y,
  input  logic                         q_pop
);

  // Two-entry request queue between the port and the sequencer.
  ccp_pkg::cmd_t           cmd_r [2];
  logic [COORD_BITS-1:0]   x_r [2];
  logic [COORD_BITS-1:0]   y_r [2];
  logic                    wp_r;
  logic                    rp_r;
  logic [1:0]              cnt_r;
  logic                    push_w;
  logic                    pop_w;

  assign in_stall = (cnt_r == 2'd2);
  assign push_w   = in_valid && !in_stall;
  assign pop_w    = q_pop && q_valid;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = cmd_r[rp_r];
  assign q_x      = x_r[rp_r];
  assign q_y      = y_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_w) begin
        cmd_r[wp_r] <= in_command;
        x_r[wp_r]   <= in_coord_x;
        y_r[wp_r]   <= in_coord_y;
        wp_r        <= !wp_r;
      end
      if (pop_w) begin
        rp_r <= !rp_r;
      end
      if (push_w && !pop_w) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop_w && !push_w) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

>>> rtl/ccp_lerp.sv
module ccp_lerp #(
  parameter int COORD_BITS = ccp_pkg::COORD_BITS,
  localparam int DW = COORD_BITS + 1,
  localparam int NW = 2 * DW + 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] a,
  input  logic signed [DW-1:0]         d,
  input  logic [NW-1:0]                num,
  input  logic [NW-1:0]                den,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] res
);

  // res = a + d * num / den, rounded half away from zero, with num <= den.
  // The product is built from two partial products, then a restoring
  // divider produces one quotient bit per cycle.
  localparam int CB  = COORD_BITS;
  localparam int NH  = (NW + 1) / 2;
  localparam int NHI = NW - NH;
  localparam int DVW = CB + NW + 1;
  localparam int QN  = CB;
  localparam int CNW = $clog2(QN + 1);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_HI   = 2'd1;
  localparam logic [1:0] L_ADD  = 2'd2;
  localparam logic [1:0] L_DIV  = 2'd3;

  logic [1:0]           ph_r;
  logic                 done_r;
  logic [CB-1:0]        mag_r;
  logic                 neg_r;
  logic [CB-1:0]        a_r;
  logic [NHI-1:0]       num_hi_r;
  logic [NW-1:0]        den_r;
  logic [DVW-1:0]       acc_r;
  logic [NW-1:0]        rem_r;
  logic [QN-1:0]        lo_r;
  logic [CNW-1:0]       cnt_r;

  logic [DW-1:0]        dneg_w;
  logic [CB-1:0]        mag_w;
  logic [CB+NH-1:0]     plo_w;
  logic [CB+NHI-1:0]    phi_w;
  logic [DVW-1:0]       sum_hi_w;
  logic [DVW-1:0]       dvd_w;
  logic [NW:0]          t_w;
  logic [NW:0]          diff_w;
  logic                 ge_w;

  assign dneg_w   = -d;
  assign mag_w    = d[DW-1] ? dneg_w[CB-1:0] : d[CB-1:0];
  assign plo_w    = mag_w * num[NH-1:0];
  assign phi_w    = mag_r * num_hi_r;
  assign sum_hi_w = acc_r + (DVW'(phi_w) << NH);
  assign dvd_w    = acc_r + DVW'(den_r >> 1);
  assign t_w      = {rem_r, lo_r[QN-1]};
  assign diff_w   = t_w - {1'b0, den_r};
  assign ge_w     = (t_w >= {1'b0, den_r});

  assign done = done_r;
  assign res  = neg_r ? (a_r - lo_r) : (a_r + lo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (ph_r)
        L_IDLE: begin
          if (start) begin
            mag_r    <= mag_w;
            neg_r    <= d[DW-1];
            a_r      <= a;
            num_hi_r <= num[NW-1:NH];
            den_r    <= den;
            acc_r    <= DVW'(plo_w);
            ph_r     <= L_HI;
          end
        end
        L_HI: begin
          acc_r <= sum_hi_w;
          ph_r  <= L_ADD;
        end
        L_ADD: begin
          rem_r <= dvd_w[QN+NW-1:QN];
          lo_r  <= dvd_w[QN-1:0];
          cnt_r <= '0;
          ph_r  <= L_DIV;
        end
        L_DIV: begin
          rem_r <= ge_w ? diff_w[NW-1:0] : t_w[NW-1:0];
          lo_r  <= {lo_r[QN-2:0], ge_w};
          cnt_r <= cnt_r + CNW'(1);
          if (cnt_r == CNW'(QN - 1)) begin
            ph_r   <= L_IDLE;
            done_r <= 1'b1;
          end
        end
        default: ph_r <= L_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/ccp_back.sv
module ccp_back #(
  parameter int MAX_CLIP_VERTICES = ccp_pkg::MAX_CLIP_VERTICES,
  parameter int MAX_LIST_VERTICES = ccp_pkg::MAX_LIST_VERTICES,
  parameter int COORD_BITS        = ccp_pkg::COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  ccp_pkg::cmd_t                q_cmd,
  input  logic signed [COORD_BITS-1:0] q_x,
  input  logic signed [COORD_BITS-1:0] q_y,
  output logic                         q_pop,
  output logic                         o_valid,
  input  logic                         o_stall,
  output logic signed [COORD_BITS-1:0] o_x,
  output logic signed [COORD_BITS-1:0] o_y,
  output logic                         o_last,
  output logic                         o_empty,
  output logic                         o_ovf
);

  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 1;
  localparam int PRW = 2 * DW;
  localparam int CRW = PRW + 1;
  localparam int NW  = CRW + 1;
  localparam int VW  = 2 * CB;
  localparam int CAW = $clog2(MAX_CLIP_VERTICES);
  localparam int CCW = $clog2(MAX_CLIP_VERTICES + 1);
  localparam int LAW = $clog2(MAX_LIST_VERTICES);
  localparam int LCW = $clog2(MAX_LIST_VERTICES + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RC0  = 4'd1;
  localparam logic [3:0] S_RC1  = 4'd2;
  localparam logic [3:0] S_RC2  = 4'd3;
  localparam logic [3:0] S_XM   = 4'd4;
  localparam logic [3:0] S_XS   = 4'd5;
  localparam logic [3:0] S_VRD  = 4'd6;
  localparam logic [3:0] S_VLD  = 4'd7;
  localparam logic [3:0] S_LW   = 4'd8;
  localparam logic [3:0] S_PE   = 4'd9;
  localparam logic [3:0] S_NX   = 4'd10;
  localparam logic [3:0] S_ORD  = 4'd11;
  localparam logic [3:0] S_OWR  = 4'd12;
  localparam logic [3:0] S_OEMP = 4'd13;

  logic [3:0]            state_r;
  logic [3:0]            state_nxt;
  logic [CCW-1:0]        clip_cnt_r;
  logic [LCW-1:0]        subj_cnt_r;
  logic                  ovf_r;
  logic [CCW-1:0]        i_r;
  logic [LCW-1:0]        n_r;
  logic [LCW-1:0]        m_r;
  logic [LCW-1:0]        k_r;
  logic                  sel_r;
  logic                  init_r;
  logic [CB-1:0]         c0x_r;
  logic [CB-1:0]         c0y_r;
  logic [DW-1:0]         cdx_r;
  logic [DW-1:0]         cdy_r;
  logic [CB-1:0]         ptx_r;
  logic [CB-1:0]         pty_r;
  logic [CB-1:0]         sx_r;
  logic [CB-1:0]         sy_r;
  logic signed [PRW-1:0] p1_r;
  logic signed [PRW-1:0] p2_r;
  logic [CRW-1:0]        cs_r;
  logic [CRW-1:0]        ce_r;
  logic                  o_valid_r;
  logic [CB-1:0]         o_x_r;
  logic [CB-1:0]         o_y_r;
  logic                  o_last_r;
  logic                  o_empty_r;
  logic                  o_ovf_r;

  logic                  clip_we;
  logic                  subj_we;
  logic                  push_en;
  logic                  push_ok;
  logic [VW-1:0]         push_data;
  logic                  ovf_set;
  logic                  lerp_start;
  logic                  out_load;
  logic                  free_w;

  logic [CCW-1:0]        i_plus_w;
  logic [CCW-1:0]        i_wrap_w;
  logic [LCW-1:0]        nm1_w;
  logic                  k_last_w;
  logic [CAW-1:0]        clip_raddr;
  logic [VW-1:0]         clip_rdata;
  logic [LAW-1:0]        lst_raddr;
  logic [VW-1:0]         rdata_a;
  logic [VW-1:0]         rdata_b;
  logic [VW-1:0]         cur_rdata;
  logic                  we_a;
  logic                  we_b;
  logic [LAW-1:0]        waddr_a;
  logic [VW-1:0]         wdata_a;
  logic [CB-1:0]         cl_x_w;
  logic [CB-1:0]         cl_y_w;
  logic [CB-1:0]         ls_x_w;
  logic [CB-1:0]         ls_y_w;

  logic signed [DW-1:0]  dxp_w;
  logic signed [DW-1:0]  dyp_w;
  logic signed [PRW-1:0] p1_w;
  logic signed [PRW-1:0] p2_w;
  logic [CRW-1:0]        cr_w;
  logic                  sin_w;
  logic                  ein_w;
  logic [NW-1:0]         csx_w;
  logic [NW-1:0]         cex_w;
  logic [NW-1:0]         num_w;
  logic [NW-1:0]         den_w;
  logic signed [DW-1:0]  ddx_w;
  logic signed [DW-1:0]  ddy_w;
  logic                  done_x;
  logic                  done_y;
  logic signed [CB-1:0]  res_x;
  logic signed [CB-1:0]  res_y;

  // Storage: clip polygon and two ping-pong vertex lists.
  ccp_ram #(.WIDTH(VW), .DEPTH(MAX_CLIP_VERTICES)) u_clip_ram (
    .clk   (clk),
    .we    (clip_we),
    .waddr (clip_cnt_r[CAW-1:0]),
    .wdata ({q_x, q_y}),
    .raddr (clip_raddr),
    .rdata (clip_rdata)
  );

  ccp_ram #(.WIDTH(VW), .DEPTH(MAX_LIST_VERTICES)) u_list_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata_a),
    .raddr (lst_raddr),
    .rdata (rdata_a)
  );

  ccp_ram #(.WIDTH(VW), .DEPTH(MAX_LIST_VERTICES)) u_list_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (m_r[LAW-1:0]),
    .wdata (push_data),
    .raddr (lst_raddr),
    .rdata (rdata_b)
  );

  ccp_lerp #(.COORD_BITS(CB)) u_lerp_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .a     (sx_r),
    .d     (ddx_w),
    .num   (num_w),
    .den   (den_w),
    .done  (done_x),
    .res   (res_x)
  );

  ccp_lerp #(.COORD_BITS(CB)) u_lerp_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .a     (sy_r),
    .d     (ddy_w),
    .num   (num_w),
    .den   (den_w),
    .done  (done_y),
    .res   (res_y)
  );

  assign i_plus_w   = i_r + CCW'(1);
  assign i_wrap_w   = (i_plus_w == clip_cnt_r) ? '0 : i_plus_w;
  assign clip_raddr = (state_r == S_RC1) ? i_wrap_w[CAW-1:0] : i_r[CAW-1:0];
  assign nm1_w      = n_r - LCW'(1);
  assign lst_raddr  = (state_r == S_RC1) ? nm1_w[LAW-1:0] : k_r[LAW-1:0];
  assign k_last_w   = ((k_r + LCW'(1)) == n_r);
  assign cur_rdata  = sel_r ? rdata_b : rdata_a;
  assign cl_x_w     = clip_rdata[VW-1:CB];
  assign cl_y_w     = clip_rdata[CB-1:0];
  assign ls_x_w     = cur_rdata[VW-1:CB];
  assign ls_y_w     = cur_rdata[CB-1:0];

  assign push_ok = push_en && (m_r < LCW'(MAX_LIST_VERTICES));
  assign we_a    = subj_we || (push_ok && sel_r);
  assign we_b    = push_ok && !sel_r;
  assign waddr_a = subj_we ? subj_cnt_r[LAW-1:0] : m_r[LAW-1:0];
  assign wdata_a = subj_we ? {q_x, q_y} : push_data;

  // Edge test: cross of edge direction with the point relative to c0.
  assign dxp_w = {ptx_r[CB-1], ptx_r} - {c0x_r[CB-1], c0x_r};
  assign dyp_w = {pty_r[CB-1], pty_r} - {c0y_r[CB-1], c0y_r};
  assign p1_w  = $signed(cdx_r) * dyp_w;
  assign p2_w  = $signed(cdy_r) * dxp_w;
  assign cr_w  = {p1_r[PRW-1], p1_r} - {p2_r[PRW-1], p2_r};
  assign sin_w = !cs_r[CRW-1];
  assign ein_w = !cr_w[CRW-1];

  // The start cross is the numerator and the difference of the two crosses
  // is the denominator, so a crossing always gives a parameter in 0..1.
  assign csx_w = {cs_r[CRW-1], cs_r};
  assign cex_w = {cr_w[CRW-1], cr_w};
  assign num_w = sin_w ? csx_w : (NW'(0) - csx_w);
  assign den_w = sin_w ? (csx_w - cex_w) : (cex_w - csx_w);
  assign ddx_w = {ptx_r[CB-1], ptx_r} - {sx_r[CB-1], sx_r};
  assign ddy_w = {pty_r[CB-1], pty_r} - {sy_r[CB-1], sy_r};

  assign free_w  = !o_valid_r || !o_stall;
  assign o_valid = o_valid_r;
  assign o_x     = o_x_r;
  assign o_y     = o_y_r;
  assign o_last  = o_last_r;
  assign o_empty = o_empty_r;
  assign o_ovf   = o_ovf_r;

  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    clip_we    = 1'b0;
    subj_we    = 1'b0;
    push_en    = 1'b0;
    push_data  = {ptx_r, pty_r};
    ovf_set    = 1'b0;
    lerp_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          unique case (q_cmd)
            ccp_pkg::CMD_CLEAR_CLIP: begin
            end
            ccp_pkg::CMD_ADD_CLIP: begin
              if (clip_cnt_r < CCW'(MAX_CLIP_VERTICES)) begin
                clip_we = 1'b1;
              end else begin
                ovf_set = 1'b1;
              end
            end
            ccp_pkg::CMD_ADD_SUBJECT: begin
              if (subj_cnt_r < LCW'(MAX_LIST_VERTICES)) begin
                subj_we = 1'b1;
              end else begin
                ovf_set = 1'b1;
              end
            end
            ccp_pkg::CMD_RUN: begin
              if ((clip_cnt_r == '0) || (subj_cnt_r == '0)) begin
                state_nxt = S_ORD;
              end else begin
                state_nxt = S_RC0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RC0: state_nxt = S_RC1;
      S_RC1: state_nxt = S_RC2;
      S_RC2: state_nxt = S_XM;
      S_XM:  state_nxt = S_XS;
      S_XS: begin
        if (init_r) begin
          state_nxt = S_VRD;
        end else if (ein_w != sin_w) begin
          lerp_start = 1'b1;
          state_nxt  = S_LW;
        end else if (ein_w) begin
          state_nxt = S_PE;
        end else begin
          state_nxt = S_NX;
        end
      end
      S_VRD: state_nxt = S_VLD;
      S_VLD: state_nxt = S_XM;
      S_LW: begin
        if (done_x && done_y) begin
          push_en   = 1'b1;
          push_data = {res_x, res_y};
          state_nxt = ce_r[CRW-1] ? S_NX : S_PE;
        end
      end
      S_PE: begin
        push_en   = 1'b1;
        state_nxt = S_NX;
      end
      S_NX: begin
        if (k_last_w) begin
          if ((i_plus_w == clip_cnt_r) || (m_r == '0)) begin
            state_nxt = S_ORD;
          end else begin
            state_nxt = S_RC0;
          end
        end else begin
          state_nxt = S_VRD;
        end
      end
      S_ORD: state_nxt = (n_r == '0) ? S_OEMP : S_OWR;
      S_OWR: begin
        if (free_w) begin
          out_load  = 1'b1;
          state_nxt = k_last_w ? S_IDLE : S_ORD;
        end
      end
      S_OEMP: begin
        if (free_w) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (push_en && !push_ok) begin
      ovf_set = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      clip_cnt_r <= '0;
      subj_cnt_r <= '0;
      ovf_r      <= 1'b0;
      m_r        <= '0;
      o_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ovf_set) begin
        ovf_r <= 1'b1;
      end
      if (clip_we) begin
        clip_cnt_r <= clip_cnt_r + CCW'(1);
      end
      if (subj_we) begin
        subj_cnt_r <= subj_cnt_r + LCW'(1);
      end
      if (push_ok) begin
        m_r <= m_r + LCW'(1);
      end
      if (out_load) begin
        o_valid_r <= 1'b1;
      end else if (o_valid_r && !o_stall) begin
        o_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid && (q_cmd == ccp_pkg::CMD_CLEAR_CLIP)) begin
            clip_cnt_r <= '0;
          end
          if (q_valid && (q_cmd == ccp_pkg::CMD_RUN)) begin
            n_r   <= subj_cnt_r;
            sel_r <= 1'b0;
            i_r   <= '0;
            k_r   <= '0;
          end
        end
        S_RC0: begin
          m_r    <= '0;
          init_r <= 1'b1;
        end
        S_RC1: begin
          c0x_r <= cl_x_w;
          c0y_r <= cl_y_w;
        end
        S_RC2: begin
          cdx_r <= {cl_x_w[CB-1], cl_x_w} - {c0x_r[CB-1], c0x_r};
          cdy_r <= {cl_y_w[CB-1], cl_y_w} - {c0y_r[CB-1], c0y_r};
          ptx_r <= ls_x_w;
          pty_r <= ls_y_w;
        end
        S_XM: begin
          p1_r <= p1_w;
          p2_r <= p2_w;
        end
        S_XS: begin
          if (init_r) begin
            cs_r   <= cr_w;
            sx_r   <= ptx_r;
            sy_r   <= pty_r;
            init_r <= 1'b0;
          end else begin
            ce_r <= cr_w;
          end
        end
        S_VLD: begin
          ptx_r <= ls_x_w;
          pty_r <= ls_y_w;
        end
        S_NX: begin
          sx_r <= ptx_r;
          sy_r <= pty_r;
          cs_r <= ce_r;
          if (k_last_w) begin
            n_r   <= m_r;
            sel_r <= !sel_r;
            i_r   <= i_plus_w;
            k_r   <= '0;
          end else begin
            k_r <= k_r + LCW'(1);
          end
        end
        S_OWR: begin
          if (free_w) begin
            o_x_r     <= ls_x_w;
            o_y_r     <= ls_y_w;
            o_last_r  <= k_last_w;
            o_empty_r <= 1'b0;
            o_ovf_r   <= ovf_r;
            k_r       <= k_r + LCW'(1);
            if (k_last_w) begin
              subj_cnt_r <= '0;
              ovf_r      <= 1'b0;
            end
          end
        end
        S_OEMP: begin
          if (free_w) begin
            o_x_r      <= '0;
            o_y_r      <= '0;
            o_last_r   <= 1'b1;
            o_empty_r  <= 1'b1;
            o_ovf_r    <= ovf_r;
            subj_cnt_r <= '0;
            ovf_r      <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_CLIP_VERTICES = ccp_pkg::MAX_CLIP_VERTICES;
  localparam int MAX_LIST_VERTICES = ccp_pkg::MAX_LIST_VERTICES;
  localparam int COORD_BITS        = ccp_pkg::COORD_BITS;

  typedef ccp_pkg::cmd_t cmd_t;

  localparam cmd_t CMD_CLEAR_CLIP  = ccp_pkg::CMD_CLEAR_CLIP;
  localparam cmd_t CMD_ADD_CLIP    = ccp_pkg::CMD_ADD_CLIP;
  localparam cmd_t CMD_ADD_SUBJECT = ccp_pkg::CMD_ADD_SUBJECT;
  localparam cmd_t CMD_RUN         = ccp_pkg::CMD_RUN;

  localparam int HALF_PERIOD  = 4;
  localparam int RANDOM_ITEMS = 360;

  // A vertex held at full precision, so the arithmetic below is exact.
  typedef struct {
    longint x;
    longint y;
  } point_t;

  // One result request as the clipper should produce it.
  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;
    logic                         empty;
    logic                         ovf;
  } vertex_out_t;

  // One row of the directed table. When typed is set, the row's own
  // expectation is checked in place of the predicted one.
  typedef struct {
    cmd_t                         cmd;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    bit                           typed;
    vertex_out_t                  want;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  cmd_t                         in_command = CMD_CLEAR_CLIP;
  logic signed [COORD_BITS-1:0] in_coord_x = '0;
  logic signed [COORD_BITS-1:0] in_coord_y = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         out_last_vertex;
  logic                         out_empty_result;
  logic                         out_overflowed;

  // Shadow copy of the clipper state.
  point_t clip_pts [MAX_CLIP_VERTICES];
  int     clip_n = 0;
  point_t subject_q [$];
  bit     ovf_seen = 1'b0;

  vertex_out_t run_out_q [$];   // Results of the latest predicted run.
  vertex_out_t pending_q [$];   // Results still owed by the clipper.
  int          err_cnt = 0;
  int          item_cnt = 0;
  bit          quiet = 1'b0;    // Set during the stretch with no idling.

  convex_polygon_clipper u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_last_vertex  (out_last_vertex),
    .out_empty_result (out_empty_result),
    .out_overflowed   (out_overflowed)
  );

  always #HALF_PERIOD clk = ~clk;

  // The timeout is far longer than the slowest correct run can take.
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  // A point is inside when it lies left of or on the directed edge c0 to c1.
  function automatic bit is_inside(point_t p, point_t c0, point_t c1);
    return cross2(c1.x - c0.x, c1.y - c0.y, p.x - c0.x, p.y - c0.y) >= 0;
  endfunction

  // Returns a + d * num / den, rounded to nearest with ties away from zero.
  // The caller guarantees that den is positive.
  function automatic longint lerp_near(longint a, longint d, longint num, longint den);
    longint prod;
    longint mag;
    longint q;
    prod = d * num;
    mag  = (prod < 0) ? -prod : prod;
    q    = (mag + den / 2) / den;
    return (prod < 0) ? a - q : a + q;
  endfunction

  // Finds where segment s to e crosses the clip edge. A parallel segment
  // gives no point, and so does a parameter outside zero to one.
  function automatic bit edge_hit(point_t s, point_t e, point_t c0, point_t c1,
                                  output point_t r);
    longint abx;
    longint aby;
    longint cdx;
    longint cdy;
    longint den;
    longint num;
    abx = e.x - s.x;
    aby = e.y - s.y;
    cdx = c1.x - c0.x;
    cdy = c1.y - c0.y;
    den = cross2(abx, aby, cdx, cdy);
    num = cross2(c0.x - s.x, c0.y - s.y, cdx, cdy);
    r   = '{0, 0};
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num < 0 || num > den) return 1'b0;
    r.x = lerp_near(s.x, abx, num, den);
    r.y = lerp_near(s.y, aby, num, den);
    return 1'b1;
  endfunction

  // Appends a vertex to a pass list. When the list is full the vertex is
  // dropped and the overflow flag is set.
  task automatic list_push(ref point_t lst [$], input point_t v);
    if (lst.size() < MAX_LIST_VERTICES) begin
      lst.insert(lst.size(), v);
    end else begin
      ovf_seen = 1'b1;
    end
  endtask

  // Updates the shadow state for one accepted request. A run request also
  // fills run_out_q with the vertices that the clipper should send.
  task automatic clip_predict(cmd_t cmd, logic signed [COORD_BITS-1:0] x,
                              logic signed [COORD_BITS-1:0] y);
    point_t p;
    point_t cur [$];
    point_t nxt [$];
    point_t c0;
    point_t c1;
    point_t s;
    point_t e;
    point_t hit;
    vertex_out_t r;
    bit e_in;
    bit s_in;
    p = '{longint'(x), longint'(y)};
    run_out_q.delete();
    case (cmd)
      CMD_CLEAR_CLIP: begin
        clip_n = 0;
      end
      CMD_ADD_CLIP: begin
        if (clip_n < MAX_CLIP_VERTICES) begin
          clip_pts[clip_n] = p;
          clip_n++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      CMD_ADD_SUBJECT: begin
        list_push(subject_q, p);
      end
      default: begin
        cur = subject_q;
        for (int i = 0; i < clip_n && cur.size() > 0; i++) begin
          c0 = clip_pts[i];
          c1 = clip_pts[(i + 1) % clip_n];
          nxt.delete();
          // Each pass starts from the last vertex of the current list.
          s = cur[cur.size() - 1];
          foreach (cur[k]) begin
            e    = cur[k];
            e_in = is_inside(e, c0, c1);
            s_in = is_inside(s, c0, c1);
            if (e_in) begin
              if (!s_in && edge_hit(s, e, c0, c1, hit)) list_push(nxt, hit);
              list_push(nxt, e);
            end else if (s_in) begin
              if (edge_hit(s, e, c0, c1, hit)) list_push(nxt, hit);
            end
            s = e;
          end
          cur = nxt;
        end
        if (cur.size() == 0) begin
          // A polygon that is empty or clipped away gives a single result.
          r = '{'0, '0, 1'b1, 1'b1, ovf_seen};
          run_out_q.insert(run_out_q.size(), r);
        end else begin
          foreach (cur[k]) begin
            r.x     = cur[k].x[COORD_BITS-1:0];
            r.y     = cur[k].y[COORD_BITS-1:0];
            r.last  = (k == cur.size() - 1);
            r.empty = 1'b0;
            r.ovf   = ovf_seen;
            run_out_q.insert(run_out_q.size(), r);
          end
        end
        // A run clears the subject and the overflow flag and keeps the clip.
        subject_q.delete();
        ovf_seen = 1'b0;
      end
    endcase
  endtask

  // Drives one request and holds it until the clipper takes it. Any idle
  // cycles come before valid is raised. Valid stays high after the request
  // so that back-to-back requests never lower and raise it in one step.
  task automatic send_req(cmd_t cmd, logic signed [COORD_BITS-1:0] x,
                          logic signed [COORD_BITS-1:0] y);
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_coord_x <= x;
    in_coord_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    clip_predict(cmd, x, y);
    item_cnt++;
  endtask

  // Most coordinates fall in a moderate window so that clips cross often.
  // The rest use the full range so that every bit toggles.
  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(99) < 65) return COORD_BITS'($urandom_range(8000) - 4000);
    return w[COORD_BITS-1:0];
  endfunction

  // Clears the clip polygon and loads a new one of a random shape.
  task automatic load_clip_shape();
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [COORD_BITS-1:0] tx [3];
    logic signed [COORD_BITS-1:0] ty [3];
    logic signed [COORD_BITS-1:0] sw;
    int shape;
    int cnt;
    shape = $urandom_range(9);
    send_req(CMD_CLEAR_CLIP, pick_coord(), pick_coord());
    if (shape < 4) begin
      // Axis-aligned rectangle, counterclockwise.
      x0 = COORD_BITS'($urandom_range(3000) - 3000);
      y0 = COORD_BITS'($urandom_range(3000) - 3000);
      x1 = COORD_BITS'($urandom_range(3000) + 16);
      y1 = COORD_BITS'($urandom_range(3000) + 16);
      send_req(CMD_ADD_CLIP, x0, y0);
      send_req(CMD_ADD_CLIP, x1, y0);
      send_req(CMD_ADD_CLIP, x1, y1);
      send_req(CMD_ADD_CLIP, x0, y1);
    end else if (shape < 7) begin
      // Triangle, with two corners swapped when it winds clockwise.
      for (int i = 0; i < 3; i++) begin
        tx[i] = pick_coord();
        ty[i] = pick_coord();
      end
      if (cross2(tx[1] - tx[0], ty[1] - ty[0], tx[2] - tx[0], ty[2] - ty[0]) < 0) begin
        sw = tx[1]; tx[1] = tx[2]; tx[2] = sw;
        sw = ty[1]; ty[1] = ty[2]; ty[2] = sw;
      end
      for (int i = 0; i < 3; i++) send_req(CMD_ADD_CLIP, tx[i], ty[i]);
    end else if (shape == 7) begin
      // Clockwise rectangle: everything is clipped away.
      send_req(CMD_ADD_CLIP, -16'sd1000, -16'sd1000);
      send_req(CMD_ADD_CLIP, -16'sd1000, 16'sd1000);
      send_req(CMD_ADD_CLIP, 16'sd1000, 16'sd1000);
      send_req(CMD_ADD_CLIP, 16'sd1000, -16'sd1000);
    end else begin
      // Loose points, from none up to past the store's capacity.
      cnt = $urandom_range(MAX_CLIP_VERTICES + 2);
      for (int i = 0; i < cnt; i++) send_req(CMD_ADD_CLIP, pick_coord(), pick_coord());
    end
  endtask

  // Receiver side: stalls at random except during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 12);
  end

  // Checks each accepted result request against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result x=%0d y=%0d", out_x, out_y);
      end else begin
        if (out_x !== pending_q[0].x || out_y !== pending_q[0].y ||
            out_last_vertex !== pending_q[0].last ||
            out_empty_result !== pending_q[0].empty ||
            out_overflowed !== pending_q[0].ovf) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch: expected x=%0d y=%0d last=%0b empty=%0b ovf=%0b",
                     pending_q[0].x, pending_q[0].y, pending_q[0].last,
                     pending_q[0].empty, pending_q[0].ovf);
            $display("          actual   x=%0d y=%0d last=%0b empty=%0b ovf=%0b",
                     out_x, out_y, out_last_vertex, out_empty_result, out_overflowed);
          end
        end
        void'(pending_q.pop_front());
      end
    end
  end

  dir_row_t dir_tab [25];

  initial begin
    int n_sub;
    int wait_cnt;

    // Directed table. Rows with typed expectations are the ones that can be
    // read off directly: runs after reset, extreme vertices that pass
    // through unchanged, and a subject that is clipped away completely.
    dir_tab = '{
      // A run right after reset gives a single empty result.
      '{CMD_RUN,         16'sd0,      16'sd0,      1'b1, '{16'sd0, 16'sd0, 1, 1, 0}},
      // With no clip polygon the extreme vertex passes through unchanged.
      '{CMD_ADD_SUBJECT, 16'sh7fff,   16'sh8000,   1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_RUN,         16'sd0,      16'sd0,      1'b1, '{16'sh7fff, 16'sh8000, 1, 0, 0}},
      // A one-vertex clip polygon has a degenerate edge, so all is inside.
      '{CMD_ADD_CLIP,    16'sd0,      16'sd0,      1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_ADD_SUBJECT, 16'sh8000,   16'sh7fff,   1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_ADD_SUBJECT, 16'sd0,      16'sd0,      1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_RUN,         16'sd0,      16'sd0,      1'b0, '{0, 0, 0, 0, 0}},
      // A square clip polygon and a triangle that crosses it.
      '{CMD_CLEAR_CLIP,  16'sh7fff,   16'sh7fff,   1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_ADD_CLIP,    16'sd0,      16'sd0,      1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_ADD_CLIP,    16'sd1600,   16'sd0,      1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_ADD_CLIP,    16'sd1600,   16'sd1600,   1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_ADD_CLIP,    16'sd0,      16'sd1600,   1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_ADD_SUBJECT, -16'sd800,   16'sd800,    1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_ADD_SUBJECT, 16'sd800,    -16'sd800,   1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_ADD_SUBJECT, 16'sd2400,   16'sd2400,   1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_RUN,         16'sd0,      16'sd0,      1'b0, '{0, 0, 0, 0, 0}},
      // A subject below the first edge is clipped away.
      '{CMD_ADD_SUBJECT, -16'sd100,   -16'sd100,   1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_ADD_SUBJECT, -16'sd200,   -16'sd100,   1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_ADD_SUBJECT, -16'sd150,   -16'sd200,   1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_RUN,         16'sd0,      16'sd0,      1'b1, '{16'sd0, 16'sd0, 1, 1, 0}},
      // One subject segment lies on a clip edge, so its crossing is parallel.
      '{CMD_ADD_SUBJECT, 16'sd800,    16'sd0,      1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_ADD_SUBJECT, 16'sd1200,   16'sd0,      1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_ADD_SUBJECT, 16'sd2000,   16'sd800,    1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_RUN,         16'sd0,      16'sd0,      1'b0, '{0, 0, 0, 0, 0}},
      '{CMD_CLEAR_CLIP,  16'sh8000,   16'sh8000,   1'b0, '{0, 0, 0, 0, 0}}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].cmd, dir_tab[i].x, dir_tab[i].y);
      if (dir_tab[i].typed) begin
        pending_q.insert(pending_q.size(), dir_tab[i].want);
      end else begin
        foreach (run_out_q[k]) pending_q.insert(pending_q.size(), run_out_q[k]);
      end
    end

    // Random part. Each round sends subjects and a run, some after a new clip shape.
    // Now and then a run has no subject, or the clip store overflows.
    item_cnt = 0;
    while (item_cnt < RANDOM_ITEMS) begin
      quiet = (item_cnt >= 150 && item_cnt < 230);
      if ($urandom_range(2) == 0) load_clip_shape();
      n_sub = ($urandom_range(9) == 0) ? $urandom_range(MAX_LIST_VERTICES + 3,
                                                        MAX_LIST_VERTICES - 1)
                                       : $urandom_range(8);
      for (int i = 0; i < n_sub; i++) begin
        send_req(CMD_ADD_SUBJECT, pick_coord(), pick_coord());
      end
      send_req(CMD_RUN, pick_coord(), pick_coord());
      foreach (run_out_q[k]) pending_q.insert(pending_q.size(), run_out_q[k]);
    end
    in_valid <= 1'b0;

    // Drain the owed results, then give the clipper time to show any extra.
    wait_cnt = 0;
    while (pending_q.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (300) @(posedge clk);
    err_cnt += pending_q.size();

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
